/* design/modbus_rtu_slave_register_bank_unit_macros.svh */
// Assertion macros, included by the datapath.
`ifndef MODBUS_RTU_SLAVE_REGISTER_BANK_UNIT_MACROS_SVH
`define MODBUS_RTU_SLAVE_REGISTER_BANK_UNIT_MACROS_SVH
`ifndef ASSERT_OFF
// Same-cycle implication, disabled during reset.
`define ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define ASSERT_IMPL(lbl, clk, rst, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

/* design/mbrtu_pkg.sv */
package mbrtu_pkg;

   localparam int RX_BYTES   = 64;
   localparam int RX_AW      = 6;
   localparam int CNT_W      = 7;
   localparam int HOLD_REGS  = 16;
   localparam int HOLD_AW    = 4;
   localparam int INPUT_REGS = 4;
   localparam int IN_AW      = 2;
   localparam int MAX_READ   = 29;

   localparam logic [15:0] CRC_PRESET = 16'hFFFF;
   localparam logic [15:0] CRC_POLY   = 16'hA001;

   localparam logic [1:0] OP_RX_BYTE  = 2'd0;
   localparam logic [1:0] OP_END      = 2'd1;
   localparam logic [1:0] OP_SET_IN   = 2'd2;
   localparam logic [1:0] OP_READ_HLD = 2'd3;

   localparam logic [7:0] FN_READ_HOLD  = 8'd3;
   localparam logic [7:0] FN_READ_INPUT = 8'd4;
   localparam logic [7:0] FN_WRITE_ONE  = 8'd6;
   localparam logic [7:0] FN_WRITE_MULT = 8'd16;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic take;
      logic scan_start;
      logic scan_step;
      logic wr_single;
      logic wmul_start;
      logic wmul_rd;
      logic wmul_wr;
      logic emit_start;
      logic emit;
      logic finish;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic [1:0] op;
      logic       n_small;
      logic       scan_done;
      logic       frame_ok;
      logic       fn_read;
      logic       fn_single;
      logic       wmul_done;
      logic       out_free;
      logic       emit_last;
   } status_type;

   // One byte of the CRC-16, bit by bit.
   function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int i = 0; i < 8; i++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

/* design/modbus_rtu_slave_register_bank_unit.sv */
// Modbus RTU slave with a small register bank.
// Input beats on req_*: tuser carries the operation (received byte, end of
// frame, set input register, local holding register read). Received bytes
// are stored in a 64-byte buffer. End of frame holds the input while the
// buffer is scanned one byte per cycle to check CRC and header. Function 16
// then writes k values, reading each from the buffer in state S_WRD and
// writing it in S_WWR. The reply follows on rsp_* at one byte per cycle
// while the receiver does not stall, with tlast on its final byte. A frame
// with fewer than 4 bytes is dropped without a scan. A local read answers
// with one beat of tuser = 1 in the cycle after acceptance.
// Throughput is one beat per cycle for local items and received bytes while
// the sequencer is idle and the output is free. No new input beat is taken
// until a frame end's scan, writes and reply are done; the receive buffer
// has a single read port. While the receiver stalls, the output register
// holds its beat and no new input beat is taken. The csr_* channel sets the
// station address and is always ready. Reset clears the buffer count, the
// register bank and the pending output, and sets the station address to 1.
module modbus_rtu_slave_register_bank_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // rx_byte[7:0], reg_index[11:8], reg_value[27:12]
   input  logic [1:0]  req_tuser,   // operation[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // tx_byte[7:0], hold_value[15:8]
   output logic        rsp_tuser,   // kind[0]
   output logic        rsp_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_data
);

   mbrtu_pkg::cmd_type    cmd;
   mbrtu_pkg::status_type st;

   // Sequencer.
   mbrtu_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .st         (st),
      .cmd        (cmd)
   );

   // Buffer, registers, CRC and output stage.
   mbrtu_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .st         (st),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

endmodule

/* design/mbrtu_ram.sv */
module mbrtu_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port, one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/mbrtu_dp.sv */
`include "modbus_rtu_slave_register_bank_unit_macros.svh"

module mbrtu_dp (
   input  logic                 clock,
   input  logic                 reset,
   input  mbrtu_pkg::cmd_type   cmd,
   output mbrtu_pkg::status_type st,
   input  logic [1:0]           req_tuser,
   input  logic [31:0]          req_tdata,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [15:0]          rsp_tdata,
   output logic                 rsp_tuser,
   output logic                 rsp_tlast,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [7:0]           csr_data
);

   localparam int CW = mbrtu_pkg::CNT_W;
   localparam int AW = mbrtu_pkg::RX_AW;

   logic [7:0]    rx_byte;
   logic [3:0]    reg_index;
   logic [15:0]   reg_value;

   logic [7:0]    slave_addr_ff;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] scan_idx_ff, scan_idx_in;
   logic          pend_ff, pend_in;
   logic [CW-1:0] pidx_ff, pidx_in;
   logic [7:0]    hdr_ff [6];
   logic [7:0]    hdr_in [6];
   logic [15:0]   rcv_ff, rcv_in;
   logic [15:0]   crc_ff, crc_in;
   logic [CW-1:0] k_ff, k_in;
   logic          half_ff, half_in;
   logic [CW-1:0] j_ff, j_in;
   logic [7:0]    hold_ff [mbrtu_pkg::HOLD_REGS];
   logic [7:0]    hold_in [mbrtu_pkg::HOLD_REGS];
   logic [15:0]   inreg_ff [mbrtu_pkg::INPUT_REGS];
   logic [15:0]   inreg_in [mbrtu_pkg::INPUT_REGS];
   logic          ovalid_ff, ovalid_in;
   logic          okind_ff, okind_in;
   logic [7:0]    otx_ff, otx_in;
   logic [7:0]    ohold_ff, ohold_in;
   logic          olast_ff, olast_in;

   logic          ram_we;
   logic [AW-1:0] ram_raddr;
   logic [7:0]    ram_rdata;

   logic [7:0]    fn;
   logic [15:0]   start, cnt;
   logic [CW-1:0] nm2, body;
   logic [16:0]   rsel, hsel;
   logic [7:0]    hval;
   logic [15:0]   ival, dval;
   logic [7:0]    pos;
   logic [7:0]    ebyte;
   logic          is_read;

   assign rx_byte   = req_tdata[7:0];
   assign reg_index = req_tdata[11:8];
   assign reg_value = req_tdata[27:12];

   assign fn    = hdr_ff[1];
   assign start = {hdr_ff[2], hdr_ff[3]};
   assign cnt   = {hdr_ff[4], hdr_ff[5]};
   assign nm2   = count_ff - CW'(2);
   assign rsel  = {1'b0, start} + 17'(k_ff);
   assign pos   = 8'd8 + {k_ff, 1'b0};
   assign is_read = (fn == mbrtu_pkg::FN_READ_HOLD) || (fn == mbrtu_pkg::FN_READ_INPUT);
   assign body  = is_read ? (CW'(3) + {cnt[5:0], 1'b0}) : CW'(6);

   // Holding register read port, shared by local reads and responses.
   assign hsel = cmd.take ? 17'(reg_index) : rsel;
   assign hval = (hsel < 17'(mbrtu_pkg::HOLD_REGS)) ? hold_ff[hsel[mbrtu_pkg::HOLD_AW-1:0]]
                                                    : 8'h00;
   assign ival = (rsel < 17'(mbrtu_pkg::INPUT_REGS)) ? inreg_ff[rsel[mbrtu_pkg::IN_AW-1:0]]
                                                     : 16'h0000;
   assign dval = (fn == mbrtu_pkg::FN_READ_HOLD) ? {8'h00, hval} : ival;

   // Receive buffer.
   assign ram_we    = cmd.take && (req_tuser == mbrtu_pkg::OP_RX_BYTE) &&
                      (count_ff < CW'(mbrtu_pkg::RX_BYTES));
   assign ram_raddr = cmd.wmul_rd ? pos[AW-1:0] : scan_idx_ff[AW-1:0];

   mbrtu_ram #(.WIDTH(8), .DEPTH(mbrtu_pkg::RX_BYTES)) u_rx_buf (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data (rx_byte),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // Next response byte.
   always_comb begin
      ebyte = 8'h00;
      if (j_ff < body) begin
         if (is_read) begin
            case (j_ff)
               CW'(0):  ebyte = slave_addr_ff;
               CW'(1):  ebyte = fn;
               CW'(2):  ebyte = {cnt[6:0], 1'b0};
               default: ebyte = half_ff ? dval[7:0] : dval[15:8];
            endcase
         end else begin
            ebyte = hdr_ff[j_ff[2:0]];
         end
      end else if (j_ff == body) begin
         ebyte = crc_ff[7:0];
      end else begin
         ebyte = crc_ff[15:8];
      end
   end

   // Status to the controller.
   always_comb begin
      st.op        = req_tuser;
      st.n_small   = count_ff < CW'(4);
      st.scan_done = (scan_idx_ff >= count_ff) && !pend_ff;
      st.frame_ok  = (crc_ff == rcv_ff) && (hdr_ff[0] == slave_addr_ff) &&
                     (is_read || (fn == mbrtu_pkg::FN_WRITE_ONE) ||
                      (fn == mbrtu_pkg::FN_WRITE_MULT)) &&
                     (count_ff >= CW'(8)) &&
                     (!is_read || (cnt <= 16'(mbrtu_pkg::MAX_READ)));
      st.fn_read   = is_read;
      st.fn_single = fn == mbrtu_pkg::FN_WRITE_ONE;
      st.wmul_done = (16'(k_ff) >= cnt) || (pos >= 8'(nm2));
      st.out_free  = !ovalid_ff || rsp_tready;
      st.emit_last = j_ff == (body + CW'(1));
   end

   // Next-state logic of the datapath registers.
   always_comb begin
      count_in    = count_ff;
      scan_idx_in = scan_idx_ff;
      pend_in     = pend_ff;
      pidx_in     = pidx_ff;
      hdr_in      = hdr_ff;
      rcv_in      = rcv_ff;
      crc_in      = crc_ff;
      k_in        = k_ff;
      half_in     = half_ff;
      j_in        = j_ff;
      hold_in     = hold_ff;
      inreg_in    = inreg_ff;
      ovalid_in   = ovalid_ff && !rsp_tready;
      okind_in    = okind_ff;
      otx_in      = otx_ff;
      ohold_in    = ohold_ff;
      olast_in    = olast_ff;

      // Local items.
      if (cmd.take) begin
         case (req_tuser)
            mbrtu_pkg::OP_RX_BYTE: begin
               if (ram_we) begin
                  count_in = count_ff + CW'(1);
               end
            end
            mbrtu_pkg::OP_SET_IN: begin
               if (32'(reg_index) < 32'(mbrtu_pkg::INPUT_REGS)) begin
                  inreg_in[reg_index[mbrtu_pkg::IN_AW-1:0]] = reg_value;
               end
            end
            mbrtu_pkg::OP_READ_HLD: begin
               ovalid_in = 1'b1;
               okind_in  = 1'b1;
               otx_in    = 8'h00;
               ohold_in  = hval;
               olast_in  = 1'b1;
            end
            default: begin
            end
         endcase
      end

      // Frame scan: CRC over the body, capture header and received CRC.
      if (cmd.scan_start) begin
         scan_idx_in = '0;
         pend_in     = 1'b0;
         crc_in      = mbrtu_pkg::CRC_PRESET;
      end
      if (cmd.scan_step) begin
         scan_idx_in = scan_idx_ff + CW'(1);
         pend_in     = scan_idx_ff < count_ff;
         pidx_in     = scan_idx_ff;
         if (pend_ff) begin
            if (pidx_ff < nm2) begin
               crc_in = mbrtu_pkg::crc16_byte(crc_ff, ram_rdata);
            end
            if (pidx_ff < CW'(6)) begin
               hdr_in[pidx_ff[2:0]] = ram_rdata;
            end
            if (pidx_ff == nm2) begin
               rcv_in[7:0] = ram_rdata;
            end
            if (pidx_ff == (nm2 + CW'(1))) begin
               rcv_in[15:8] = ram_rdata;
            end
         end
      end

      // Register writes from the frame.
      if (cmd.wr_single && (start < 16'(mbrtu_pkg::HOLD_REGS))) begin
         hold_in[start[mbrtu_pkg::HOLD_AW-1:0]] = hdr_ff[5];
      end
      if (cmd.wmul_start) begin
         k_in = '0;
      end
      if (cmd.wmul_wr) begin
         if (rsel < 17'(mbrtu_pkg::HOLD_REGS)) begin
            hold_in[rsel[mbrtu_pkg::HOLD_AW-1:0]] = ram_rdata;
         end
         k_in = k_ff + CW'(1);
      end

      // Response bytes, with the CRC built as they go out.
      if (cmd.emit_start) begin
         j_in    = '0;
         k_in    = '0;
         half_in = 1'b0;
         crc_in  = mbrtu_pkg::CRC_PRESET;
      end
      if (cmd.emit) begin
         ovalid_in = 1'b1;
         okind_in  = 1'b0;
         otx_in    = ebyte;
         ohold_in  = 8'h00;
         olast_in  = st.emit_last;
         j_in      = j_ff + CW'(1);
         if (j_ff < body) begin
            crc_in = mbrtu_pkg::crc16_byte(crc_ff, ebyte);
         end
         if (is_read && (j_ff >= CW'(3)) && (j_ff < body)) begin
            half_in = !half_ff;
            if (half_ff) begin
               k_in = k_ff + CW'(1);
            end
         end
      end

      if (cmd.finish) begin
         count_in = '0;
      end
   end

   // Registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         slave_addr_ff <= 8'd1;
         count_ff      <= '0;
         pend_ff       <= 1'b0;
         ovalid_ff     <= 1'b0;
         for (int i = 0; i < mbrtu_pkg::HOLD_REGS; i++) begin
            hold_ff[i] <= 8'h00;
         end
         for (int i = 0; i < mbrtu_pkg::INPUT_REGS; i++) begin
            inreg_ff[i] <= 16'h0000;
         end
      end else begin
         if (csr_valid) begin
            slave_addr_ff <= csr_data;
         end
         count_ff  <= count_in;
         pend_ff   <= pend_in;
         ovalid_ff <= ovalid_in;
         hold_ff   <= hold_in;
         inreg_ff  <= inreg_in;
      end
      scan_idx_ff <= scan_idx_in;
      pidx_ff     <= pidx_in;
      hdr_ff      <= hdr_in;
      rcv_ff      <= rcv_in;
      crc_ff      <= crc_in;
      k_ff        <= k_in;
      half_ff     <= half_in;
      j_ff        <= j_in;
      okind_ff    <= okind_in;
      otx_ff      <= otx_in;
      ohold_ff    <= ohold_in;
      olast_ff    <= olast_in;
   end

   assign csr_ready  = 1'b1;
   assign rsp_tvalid = ovalid_ff;
   assign rsp_tdata  = {ohold_ff, otx_ff};
   assign rsp_tuser  = okind_ff;
   assign rsp_tlast  = olast_ff;

   // The fill count never passes the buffer size.
   `ASSERT_IMPL(a_count_bound, clock, reset, 1'b1, count_ff <= CW'(mbrtu_pkg::RX_BYTES))
   // A local read result always closes its own run.
   `ASSERT_IMPL(a_local_last, clock, reset, ovalid_ff && okind_ff, olast_ff)
   // A pending scan read always addresses a buffered byte.
   `ASSERT_IMPL(a_scan_in_range, clock, reset, pend_ff, pidx_ff < count_ff)

endmodule

/* design/mbrtu_ctrl.sv */
module mbrtu_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  mbrtu_pkg::status_type st,
   output mbrtu_pkg::cmd_type    cmd
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_SCAN  = 3'd1;
   localparam logic [2:0] S_CHECK = 3'd2;
   localparam logic [2:0] S_WRD   = 3'd3;
   localparam logic [2:0] S_WWR   = 3'd4;
   localparam logic [2:0] S_EMIT  = 3'd5;

   logic [2:0] state_ff, state_in;

   assign req_tready = (state_ff == S_IDLE) && st.out_free;

   // Frame sequencing.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid && st.out_free) begin
               cmd.take = 1'b1;
               if (st.op == mbrtu_pkg::OP_END) begin
                  if (st.n_small) begin
                     cmd.finish = 1'b1;
                  end else begin
                     cmd.scan_start = 1'b1;
                     state_in       = S_SCAN;
                  end
               end
            end
         end
         S_SCAN: begin
            if (st.scan_done) begin
               state_in = S_CHECK;
            end else begin
               cmd.scan_step = 1'b1;
            end
         end
         S_CHECK: begin
            if (!st.frame_ok) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end else if (st.fn_read) begin
               cmd.emit_start = 1'b1;
               state_in       = S_EMIT;
            end else if (st.fn_single) begin
               cmd.wr_single  = 1'b1;
               cmd.emit_start = 1'b1;
               state_in       = S_EMIT;
            end else begin
               cmd.wmul_start = 1'b1;
               state_in       = S_WRD;
            end
         end
         S_WRD: begin
            if (st.wmul_done) begin
               cmd.emit_start = 1'b1;
               state_in       = S_EMIT;
            end else begin
               cmd.wmul_rd = 1'b1;
               state_in    = S_WWR;
            end
         end
         S_WWR: begin
            cmd.wmul_wr = 1'b1;
            state_in    = S_WRD;
         end
         S_EMIT: begin
            if (st.out_free) begin
               cmd.emit = 1'b1;
               if (st.emit_last) begin
                  cmd.finish = 1'b1;
                  state_in   = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
